// ===== design/xor_checked_message_framer_top_defines.svh =====
// Assertion macros used by the message framer controller.
`ifndef XOR_CHECKED_MESSAGE_FRAMER_TOP_DEFINES_SVH
`define XOR_CHECKED_MESSAGE_FRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define XCMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("xcmf assertion failed");
// Clocked check that also holds during reset.
`define XCMF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("xcmf assertion failed");
`else
`define XCMF_ASSERT(lbl, clk, rstn, prop)
`define XCMF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/xcmf_pkg.sv =====
// Shared constants, types and functions of the message framer.
package xcmf_pkg;

  localparam int unsigned DEF_BUFFER_DEPTH = 32;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned HEAD_BYTES       = 2;
  localparam logic [7:0]  CHECK_SEED       = 8'hFF;
  localparam logic [1:0]  LEN_CODE_EXT     = 2'd3;

  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic rd_en;    // read the store at the read pointer
    logic rd_adv;   // output beat taken, move the read pointer
  } xcmf_cmd_t;

  typedef struct packed {
    logic complete; // the offered byte completes a valid message
    logic last;     // the loaded output byte is the final one
  } xcmf_status_t;

  // Message length from the opcode and the byte after it.
  function automatic logic [LEN_W-1:0] len_from_head(logic [7:0] op, logic [7:0] second);
    logic [1:0] code;
    logic [LEN_W-1:0] len;
    code = op[6:5];
    case (code)
      LEN_CODE_EXT: len = LEN_W'(second[6:0]);
      default:      len = LEN_W'({code, 1'b0}) + LEN_W'(HEAD_BYTES);
    endcase
    return len;
  endfunction

endpackage

// ===== design/xcmf_datapath.sv =====
// Datapath: byte store, fill count, length and checksum, output register.
module xcmf_datapath
  import xcmf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   rx_byte_i,
  input  xcmf_cmd_t    cmd_i,
  output xcmf_status_t status_o,
  output logic [7:0]   msg_byte_o,
  output logic         msg_last_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned FW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]       mem_q [BUFFER_DEPTH];
  logic [FW-1:0]    fill_q, fill_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       chk_q, chk_d;
  logic [7:0]       head0_q, head0_d;
  logic [7:0]       head1_q, head1_d;
  logic [AW-1:0]    rd_ptr_q;
  logic [7:0]       rdata_q;
  logic             last_q;

  logic             is_op;
  logic [FW-1:0]    fill_b, fill_n;
  logic [LEN_W-1:0] len_b;
  logic [7:0]       chk_b;
  logic             room;

  always_comb begin
    is_op  = rx_byte_i[7];
    // an opcode restarts assembly before it is stored
    fill_b = is_op ? '0 : fill_q;
    len_b  = is_op ? '0 : len_q;
    chk_b  = is_op ? CHECK_SEED : chk_q;
    room   = fill_b < FW'(BUFFER_DEPTH);
    fill_n = fill_b + FW'(1);

    fill_d  = fill_b;
    chk_d   = chk_b;
    head0_d = head0_q;
    head1_d = head1_q;
    if (room) begin
      fill_d = fill_n;
      if (fill_n <= FW'(HEAD_BYTES) || len_b >= LEN_W'(fill_n)) begin
        chk_d = chk_b ^ rx_byte_i;
      end
      if (fill_b == FW'(0)) head0_d = rx_byte_i;
      if (fill_b == FW'(1)) head1_d = rx_byte_i;
    end

    len_d = len_b;
    if (fill_d >= FW'(HEAD_BYTES) && len_b == '0) begin
      len_d = len_from_head(head0_d, head1_d);
    end

    status_o.complete = room && (LEN_W'(fill_d) == len_d) && (chk_d == 8'h00);
    status_o.last     = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      len_q    <= '0;
      chk_q    <= CHECK_SEED;
      rd_ptr_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        fill_q   <= fill_d;
        len_q    <= len_d;
        chk_q    <= chk_d;
        rd_ptr_q <= '0;
      end else if (cmd_i.rd_adv) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      head0_q <= head0_d;
      head1_q <= head1_d;
    end
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && room) begin
      mem_q[fill_b[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_ptr_q];
      last_q  <= (FW'(rd_ptr_q) + FW'(1)) == fill_q;
    end
  end

  assign msg_byte_o = rdata_q;
  assign msg_last_o = last_q;

endmodule

// ===== design/xcmf_ctrl.sv =====
// Controller: accepts bytes and sequences the read-out of a finished message.
`include "xor_checked_message_framer_top_defines.svh"

module xcmf_ctrl
  import xcmf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         rx_valid_i,
  output logic         rx_ready_o,
  output logic         msg_valid_o,
  input  logic         msg_ready_i,
  input  xcmf_status_t status_i,
  output xcmf_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    rx_ready_o   = (state_q == ST_IDLE);
    msg_valid_o  = (state_q == ST_SEND);
    cmd_o.accept = rx_ready_o && rx_valid_i;
    cmd_o.rd_en  = (state_q == ST_READ);
    cmd_o.rd_adv = msg_valid_o && msg_ready_i;

    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && status_i.complete) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (cmd_o.rd_adv) state_d = status_i.last ? ST_IDLE : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `XCMF_ASSERT(a_no_overlap, clk_i, rst_ni, !(rx_ready_o && msg_valid_o))
  `XCMF_ASSERT(a_complete_reads, clk_i, rst_ni, (cmd_o.accept && status_i.complete) |=> (state_q == ST_READ))
  `XCMF_ASSERT(a_read_then_send, clk_i, rst_ni, (state_q == ST_READ) |=> msg_valid_o)
  `XCMF_ASSERT(a_last_to_idle, clk_i, rst_ni, (cmd_o.rd_adv && status_i.last) |=> rx_ready_o)

endmodule

// ===== design/xor_checked_message_framer_top.sv =====
// Input: one byte is taken per cycle while the controller is idle; no input is taken while a
// message is read out and sent. After the byte that completes a message is taken, the store
// is read into the output register (ST_READ) and the first beat is offered (ST_SEND); each
// later beat repeats the read, and each beat is held in ST_SEND until msg_ready_i takes it.
// Reset (async, active low): idle, count and length cleared, checksum 0xFF; store not cleared.
module xor_checked_message_framer_top
  import xcmf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  output logic [7:0] msg_byte_o,
  output logic       msg_last_o,
  output logic       msg_valid_o,
  input  logic       msg_ready_i
);

  xcmf_cmd_t    cmd;
  xcmf_status_t status;

  xcmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .msg_valid_o (msg_valid_o),
    .msg_ready_i (msg_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xcmf_datapath #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .msg_byte_o (msg_byte_o),
    .msg_last_o (msg_last_o)
  );

endmodule
